>>> src/aahtu_pkg.sv
// Shared widths, reset values, register indexes and unit command types of the hang AGC.
package aahtu_pkg;

    // Payload and state widths
    localparam int SAMPLE_W   = 16;
    localparam int ENV_W      = 16;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int GAIN_W     = 36;
    localparam int GAIN_FRAC  = 16;
    localparam int HANG_W     = 20;
    localparam int LEVEL_W    = 15;
    localparam int MANUAL_W   = 26;
    localparam int COEF_W     = 24;
    localparam int FRAC_W     = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;

    // Shared multiply-accumulate unit
    localparam int MUL_A_W    = GAIN_W / 2;
    localparam int MUL_B_W    = COEF_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = GAIN_W + COEF_W + 1;

    // Divider: target_level * 2^16 over a 16-bit envelope
    localparam int DIVD_W     = LEVEL_W + GAIN_FRAC;
    localparam int DIVS_W     = ENV_W;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);

    // Saturation limits and envelope ceiling
    localparam int SAMPLE_MAX     = 32767;
    localparam int SAMPLE_MIN_MAG = 32768;
    localparam int ENV_MAX        = 32768;

    // Rounding offsets that turn a right shift into a ceiling
    localparam logic [COEF_W-1:0] CEIL_FRAC = {COEF_W{1'b1}};
    localparam logic [COEF_W-1:0] CEIL_OUT  = COEF_W'((1 << GAIN_FRAC) - 1);

    localparam logic [COEF_W-1:0] SMOOTH_COEFF_DEF = COEF_W'(69762);

    // Reset values
    localparam logic [GAIN_W-1:0]   GAIN_RST      = GAIN_W'(65536);
    localparam logic [COEF_W-1:0]   ATTACK_RST    = COEF_W'(173800);
    localparam logic [COEF_W-1:0]   DECAY_RST     = COEF_W'(699);
    localparam logic [HANG_W-1:0]   HANG_RST      = HANG_W'(12000);
    localparam logic [LEVEL_W-1:0]  THRESH_RST    = LEVEL_W'(33);
    localparam logic [GAIN_W-1:0]   MAX_GAIN_RST  = GAIN_W'(65536000);
    localparam logic [LEVEL_W-1:0]  TARGET_RST    = LEVEL_W'(16384);
    localparam logic [MANUAL_W-1:0] MANUAL_RST    = MANUAL_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGC_OFF   = 3'd0,
        CFG_ATTACK    = 3'd1,
        CFG_DECAY     = 3'd2,
        CFG_HANG      = 3'd3,
        CFG_THRESHOLD = 3'd4,
        CFG_MAX_GAIN  = 3'd5,
        CFG_TARGET    = 3'd6,
        CFG_MANUAL    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               load;
        logic [COEF_W-1:0]  init;
        logic               mul;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic               hi;
    } t_mac_cmd;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_sts;

endpackage

>>> src/aahtu_in_if.sv
// Input channel: one audio sample per transfer.
interface aahtu_in_if;
    import aahtu_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       first_of_block;

    modport source (output valid, output sample_in, output first_of_block, input ready);
    modport sink   (input valid, input sample_in, input first_of_block, output ready);
endinterface

>>> src/aahtu_out_if.sv
// Output channel: one gain-applied sample with its gain and envelope per transfer.
interface aahtu_out_if;
    import aahtu_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [GAIN_W-1:0]          gain_now;
    logic [ENV_W-1:0]           envelope_now;

    modport source (output valid, output sample_out, output gain_now, output envelope_now,
                    input ready);
    modport sink   (input valid, input sample_out, input gain_now, input envelope_now,
                    output ready);
endinterface

>>> src/audio_agc_hang_threshold_unit.sv
// Top level of the hang AGC with threshold floor: sequencer, state and configuration.
//
// One sample enters per transfer on i_in and one result leaves per transfer on o_out.
// The block works on one sample at a time and drops ready while it does. In automatic
// mode a sample passes through the restoring divider that forms target_level * 2^16 /
// max(envelope, threshold), 31 quotient bits at one bit per cycle, and through steps of
// the single 18x24 multiply-accumulate unit (envelope move, two-part gain smoothing,
// two-part output product), each product registered before it is accumulated. When both
// envelope and threshold are zero the divider is skipped; during hang the envelope
// multiply is skipped. In manual mode (agc_off) a sample goes straight to the output
// product. A finished result sits in an output register, so the next sample can be
// taken while it waits; a result that is still not taken when the next one is finished
// holds the sequencer in its last step.
// Configuration writes land at once; write them only while no sample is in flight.
module audio_agc_hang_threshold_unit #(
    parameter logic [aahtu_pkg::COEF_W-1:0] SMOOTH_COEFF = aahtu_pkg::SMOOTH_COEFF_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aahtu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aahtu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    aahtu_in_if.sink                            i_in,
    aahtu_out_if.source                         o_out
);
    import aahtu_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_START = 14'b00000000000010,
        S_ENV1  = 14'b00000000000100,
        S_ENV2  = 14'b00000000001000,
        S_EFF   = 14'b00000000010000,
        S_DIV   = 14'b00000000100000,
        S_GAIN0 = 14'b00000001000000,
        S_GAIN1 = 14'b00000010000000,
        S_GAIN2 = 14'b00000100000000,
        S_GAIN3 = 14'b00001000000000,
        S_OUT0  = 14'b00010000000000,
        S_OUT1  = 14'b00100000000000,
        S_OUT2  = 14'b01000000000000,
        S_OUT3  = 14'b10000000000000
    } t_state;

    localparam int OQ_W = ACC_W - GAIN_FRAC;

    // Configuration registers
    logic                r_agc_off;
    logic [COEF_W-1:0]   r_attack;
    logic [COEF_W-1:0]   r_decay;
    logic [HANG_W-1:0]   r_hang_samples;
    logic [LEVEL_W-1:0]  r_thresh;
    logic [GAIN_W-1:0]   r_max_gain;
    logic [LEVEL_W-1:0]  r_target_lvl;
    logic [MANUAL_W-1:0] r_manual_gain;

    // Loop state
    t_state              r_state;
    t_state              n_state;
    logic [ENV_W-1:0]    r_env;
    logic [GAIN_W-1:0]   r_gain;
    logic [HANG_W-1:0]   r_hang;

    // Per-sample working registers
    logic [SAMPLE_W-1:0] r_smp;
    logic                r_first;
    logic                r_down;
    logic [GAIN_W-1:0]   r_target;

    // Output register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_smp;
    logic [GAIN_W-1:0]   r_out_gain;
    logic [ENV_W-1:0]    r_out_env;

    // Shared units
    t_mac_cmd            w_mac_cmd;
    logic [ACC_W-1:0]    w_acc;
    t_div_cmd            w_div_cmd;
    t_div_sts            w_div_sts;

    logic                w_neg;
    logic [MAG_W-1:0]    w_sx;
    logic [MAG_W-1:0]    w_mag;
    logic [MAG_W-1:0]    w_env_ext;
    logic                w_env_up;
    logic [MAG_W-1:0]    w_env_diff;
    logic [MAG_W-1:0]    w_env_step;
    logic [ENV_W-1:0]    w_eff;
    logic [GAIN_W-1:0]   w_quo_ext;
    logic                w_gain_down;
    logic [GAIN_W-1:0]   w_gain_diff;
    logic [GAIN_W-1:0]   w_gain_step;
    logic [OQ_W-1:0]     w_oq;
    logic [ENV_W-1:0]    w_ay;
    logic [SAMPLE_W-1:0] w_y;
    logic [ENV_W-1:0]    w_env_off;
    logic [ENV_W-1:0]    w_env_final;
    logic                w_out_free;
    logic                w_in_xfer;

    aahtu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mac_cmd),
        .o_acc   (w_acc)
    );

    aahtu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_sts   (w_div_sts)
    );

    // ------------------------------------------------------------------
    // Configuration writes; the field width masks the data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agc_off      <= 1'b0;
            r_attack       <= ATTACK_RST;
            r_decay        <= DECAY_RST;
            r_hang_samples <= HANG_RST;
            r_thresh       <= THRESH_RST;
            r_max_gain     <= MAX_GAIN_RST;
            r_target_lvl   <= TARGET_RST;
            r_manual_gain  <= MANUAL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AGC_OFF:   r_agc_off      <= i_cfg_data[0];
                CFG_ATTACK:    r_attack       <= i_cfg_data[COEF_W-1:0];
                CFG_DECAY:     r_decay        <= i_cfg_data[COEF_W-1:0];
                CFG_HANG:      r_hang_samples <= i_cfg_data[HANG_W-1:0];
                CFG_THRESHOLD: r_thresh       <= i_cfg_data[LEVEL_W-1:0];
                CFG_MAX_GAIN:  r_max_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_TARGET:    r_target_lvl   <= i_cfg_data[LEVEL_W-1:0];
                CFG_MANUAL:    r_manual_gain  <= i_cfg_data[MANUAL_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // input magnitude, 0..32768
    assign w_neg     = r_smp[SAMPLE_W-1];
    assign w_sx      = {r_smp[SAMPLE_W-1], r_smp};
    assign w_mag     = w_neg ? (~w_sx + 1'b1) : w_sx;

    // envelope move toward the magnitude
    assign w_env_ext  = {1'b0, r_env};
    assign w_env_up   = w_mag > w_env_ext;
    assign w_env_diff = w_env_up ? (w_mag - w_env_ext) : (w_env_ext - w_mag);
    assign w_env_step = w_acc[FRAC_W +: MAG_W];

    // divisor is the envelope, floored by the threshold
    assign w_eff     = (r_env > {1'b0, r_thresh}) ? r_env : {1'b0, r_thresh};
    assign w_quo_ext = GAIN_W'(w_div_sts.quotient);

    // gain smoothing toward the target
    assign w_gain_down = r_target < r_gain;
    assign w_gain_diff = w_gain_down ? (r_gain - r_target) : (r_target - r_gain);
    assign w_gain_step = w_acc[FRAC_W +: GAIN_W];

    // output: |sample| * gain / 2^16, rounded toward minus infinity, saturated
    assign w_oq = w_acc[ACC_W-1:GAIN_FRAC];

    always_comb begin
        if (!w_neg) begin
            w_ay = (w_oq > OQ_W'(SAMPLE_MAX)) ? ENV_W'(SAMPLE_MAX) : w_oq[ENV_W-1:0];
        end else begin
            w_ay = (w_oq > OQ_W'(SAMPLE_MIN_MAG)) ? ENV_W'(SAMPLE_MIN_MAG) : w_oq[ENV_W-1:0];
        end
    end

    assign w_y         = w_neg ? (~w_ay + 1'b1) : w_ay;
    assign w_env_off   = (r_first || (w_ay > r_env)) ? w_ay : r_env;
    assign w_env_final = r_agc_off ? w_env_off : r_env;

    // ------------------------------------------------------------------
    // Sequencer: next state and commands to the shared units
    // ------------------------------------------------------------------
    always_comb begin
        n_state            = r_state;
        w_mac_cmd          = '0;
        w_div_cmd.start    = 1'b0;
        w_div_cmd.dividend = {r_target_lvl, {GAIN_FRAC{1'b0}}};
        w_div_cmd.divisor  = w_eff;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_agc_off) begin
                    n_state = S_OUT0;
                end else if (w_env_up || (r_hang == '0)) begin
                    // attack or decay move; a move down rounds its step up
                    w_mac_cmd.load = 1'b1;
                    w_mac_cmd.init = w_env_up ? '0 : CEIL_FRAC;
                    w_mac_cmd.mul  = 1'b1;
                    w_mac_cmd.a    = MUL_A_W'(w_env_diff);
                    w_mac_cmd.b    = w_env_up ? r_attack : r_decay;
                    n_state        = S_ENV1;
                end else begin
                    n_state = S_EFF;
                end
            end
            S_ENV1: n_state = S_ENV2;
            S_ENV2: n_state = S_EFF;
            S_EFF: begin
                if (w_eff == '0) begin
                    n_state = S_GAIN0;
                end else begin
                    w_div_cmd.start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_state = S_GAIN0;
                end
            end
            S_GAIN0: begin
                w_mac_cmd.load = 1'b1;
                w_mac_cmd.init = w_gain_down ? CEIL_FRAC : '0;
                w_mac_cmd.mul  = 1'b1;
                w_mac_cmd.a    = w_gain_diff[MUL_A_W-1:0];
                w_mac_cmd.b    = SMOOTH_COEFF;
                n_state        = S_GAIN1;
            end
            S_GAIN1: begin
                w_mac_cmd.mul = 1'b1;
                w_mac_cmd.a   = w_gain_diff[GAIN_W-1:MUL_A_W];
                w_mac_cmd.b   = SMOOTH_COEFF;
                w_mac_cmd.hi  = 1'b1;
                n_state       = S_GAIN2;
            end
            S_GAIN2: n_state = S_GAIN3;
            S_GAIN3: n_state = S_OUT0;
            S_OUT0: begin
                w_mac_cmd.load = 1'b1;
                w_mac_cmd.init = w_neg ? CEIL_OUT : '0;
                w_mac_cmd.mul  = 1'b1;
                w_mac_cmd.a    = MUL_A_W'(w_mag);
                w_mac_cmd.b    = MUL_B_W'(r_gain[MUL_A_W-1:0]);
                n_state        = S_OUT1;
            end
            S_OUT1: begin
                w_mac_cmd.mul = 1'b1;
                w_mac_cmd.a   = MUL_A_W'(w_mag);
                w_mac_cmd.b   = MUL_B_W'(r_gain[GAIN_W-1:MUL_A_W]);
                w_mac_cmd.hi  = 1'b1;
                n_state       = S_OUT2;
            end
            S_OUT2: n_state = S_OUT3;
            S_OUT3: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State and working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_env       <= '0;
            r_gain      <= GAIN_RST;
            r_hang      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a finished result, or drop the one just taken
            if ((r_state == S_OUT3) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_smp   <= i_in.sample_in;
                        r_first <= i_in.first_of_block;
                    end
                end
                S_START: begin
                    if (r_agc_off) begin
                        r_gain <= GAIN_W'(r_manual_gain);
                    end else if (w_env_up) begin
                        r_hang <= r_hang_samples;
                        r_down <= 1'b0;
                    end else if (r_hang != '0) begin
                        r_hang <= r_hang - 1'b1;
                    end else begin
                        r_down <= 1'b1;
                    end
                end
                S_ENV2: begin
                    r_env <= r_down ? ENV_W'(w_env_ext - w_env_step)
                                    : ENV_W'(w_env_ext + w_env_step);
                end
                S_EFF: begin
                    if (w_eff == '0) begin
                        r_target <= r_max_gain;
                    end
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_target <= (w_quo_ext > r_max_gain) ? r_max_gain : w_quo_ext;
                    end
                end
                S_GAIN0: begin
                    r_down <= w_gain_down;
                end
                S_GAIN3: begin
                    r_gain <= r_down ? (r_gain - w_gain_step) : (r_gain + w_gain_step);
                end
                S_OUT3: begin
                    if (w_out_free) begin
                        r_out_smp   <= w_y;
                        r_out_gain  <= r_gain;
                        r_out_env   <= w_env_final;
                        if (r_agc_off) begin
                            r_env <= w_env_off;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Channel ports
    // ------------------------------------------------------------------
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.sample_out   = r_out_smp;
    assign o_out.gain_now     = r_out_gain;
    assign o_out.envelope_now = r_out_env;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= ENV_W'(ENV_MAX))
        else $error("envelope above full scale");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_out_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT3))
        else $error("result loaded outside the final step");

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_div_sts.busy)
        else $error("input ready while the divider is busy");

endmodule

>>> src/aahtu_mac.sv
// Shared multiply-accumulate unit: registered 18x24 product, accumulated with optional shift.
module aahtu_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  aahtu_pkg::t_mac_cmd          i_cmd,
    output logic [aahtu_pkg::ACC_W-1:0]  o_acc
);
    import aahtu_pkg::*;

    logic [MUL_P_W-1:0] r_prod;
    logic               r_hi;
    logic               r_pend;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= i_cmd.a * i_cmd.b;
            r_hi   <= i_cmd.hi;
        end
        if (i_cmd.load) begin
            r_acc <= ACC_W'(i_cmd.init);
        end else if (r_pend) begin
            r_acc <= r_acc + w_addend;
        end
    end

    // upper partial product weighs 2^18
    assign w_addend = r_hi ? (ACC_W'(r_prod) << MUL_A_W) : ACC_W'(r_prod);
    assign o_acc    = r_acc;

    a_load_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_pend)
        else $error("accumulator loaded while a product is still pending");

endmodule

>>> src/aahtu_div.sv
// Restoring divider, one quotient bit per cycle.
module aahtu_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aahtu_pkg::t_div_cmd  i_cmd,
    output aahtu_pkg::t_div_sts  o_sts
);
    import aahtu_pkg::*;

    logic [DIVS_W-1:0]    r_rem;
    logic [DIVS_W-1:0]    r_divisor;
    logic [DIVD_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVS_W:0]      w_trial;
    logic [DIVS_W+1:0]    w_diff;
    logic                 w_ge;
    logic                 w_last;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_divisor};
    assign w_ge    = !w_diff[DIVS_W+1];
    assign w_last  = (r_cnt == DIV_CNT_W'(DIVD_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem     <= '0;
            r_quo     <= i_cmd.dividend;
            r_divisor <= i_cmd.divisor;
            r_cnt     <= '0;
        end else if (r_busy) begin
            // shift the next dividend bit in, the quotient bit in at the bottom
            r_rem <= w_ge ? w_diff[DIVS_W-1:0] : w_trial[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

>>> tb/audio_agc_hang_threshold_unit_tb.sv
// Self-checking testbench for the hang AGC unit: directed corner cases, then randomized phases.
`timescale 1ns / 1ps

module audio_agc_hang_threshold_unit_tb;
    import aahtu_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    aahtu_in_if  in_ch ();
    aahtu_out_if out_ch ();

    audio_agc_hang_threshold_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // One gain-applied sample as the block should report it.
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          gain;
        logic [ENV_W-1:0]           env;
    } t_agc_result;

    // Register copies, kept in step with every write on the configuration port.
    logic                cfg_off;
    logic [COEF_W-1:0]   cfg_attack;
    logic [COEF_W-1:0]   cfg_decay;
    logic [HANG_W-1:0]   cfg_hang;
    logic [LEVEL_W-1:0]  cfg_thresh;
    logic [GAIN_W-1:0]   cfg_max_gain;
    logic [LEVEL_W-1:0]  cfg_target;
    logic [MANUAL_W-1:0] cfg_manual;

    // Loop state of the AGC as this bench tracks it.
    logic [ENV_W-1:0]  env_st;
    logic [GAIN_W-1:0] gain_st;
    logic [HANG_W-1:0] hang_st;

    t_agc_result results_due[$];

    int  mismatch_count;
    int  samples_sent;
    int  results_seen;
    int  phases_run;
    bit  steady_flow;      // set: neither side idles
    int  burst_left;
    bit  burst_loud;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Move v toward t by c / 2^24, rounding the step toward minus infinity.
    function automatic logic [63:0] one_pole(input logic [63:0] v, input logic [63:0] t,
                                             input logic [COEF_W-1:0] c);
        logic [63:0] d;
        if (t >= v) begin
            d = t - v;
            return v + ((d * 64'(c)) >> FRAC_W);
        end
        d = v - t;
        return v - ((d * 64'(c) + ((64'd1 << FRAC_W) - 1)) >> FRAC_W);
    endfunction

    // Floor of sample times gain in Q20.16, saturated to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] apply_scale(
            input logic signed [SAMPLE_W-1:0] s, input logic [GAIN_W-1:0] g);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (s < 0) ? 64'(-int'(s)) : 64'(int'(s));
        if (s >= 0) begin
            q = (mag * 64'(g)) >> GAIN_FRAC;
            return (q > 64'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(q);
        end
        // Negative side: a ceiling on the magnitude is a floor on the signed value.
        q = (mag * 64'(g) + ((64'd1 << GAIN_FRAC) - 1)) >> GAIN_FRAC;
        return (q >= 64'(SAMPLE_MIN_MAG)) ? SAMPLE_W'(-SAMPLE_MIN_MAG) : SAMPLE_W'(-q);
    endfunction

    // Advance the tracked AGC state by one sample and return what the block must emit.
    function automatic t_agc_result agc_next_output(input logic signed [SAMPLE_W-1:0] s,
                                                    input logic first);
        t_agc_result r;
        logic [63:0] mag;
        logic [63:0] eff;
        logic [63:0] target;
        int          out_mag;
        mag = (s < 0) ? 64'(-int'(s)) : 64'(int'(s));
        if (cfg_off) begin
            // Manual gain; envelope is the output peak since the block start, hang untouched.
            gain_st  = GAIN_W'(cfg_manual);
            r.sample = apply_scale(s, gain_st);
            out_mag  = (r.sample < 0) ? -int'(r.sample) : int'(r.sample);
            if (first || out_mag > int'(env_st))
                env_st = ENV_W'(out_mag);
        end else begin
            // Attack re-arms hang; hold while hang runs; decay once it has run out.
            if (mag > 64'(env_st)) begin
                env_st  = ENV_W'(one_pole(64'(env_st), mag, cfg_attack));
                hang_st = cfg_hang;
            end else if (hang_st != '0) begin
                hang_st = hang_st - 1'b1;
            end else begin
                env_st = ENV_W'(one_pole(64'(env_st), mag, cfg_decay));
            end
            eff = (env_st > ENV_W'(cfg_thresh)) ? 64'(env_st) : 64'(cfg_thresh);
            // Zero divisor falls back to the gain ceiling; otherwise clamp to it.
            if (eff == 0)
                target = 64'(cfg_max_gain);
            else
                target = (64'(cfg_target) << GAIN_FRAC) / eff;
            if (target > 64'(cfg_max_gain))
                target = 64'(cfg_max_gain);
            // Smooth toward the target; a gain above a lowered ceiling glides down.
            gain_st  = GAIN_W'(one_pole(64'(gain_st), target, SMOOTH_COEFF_DEF));
            r.sample = apply_scale(s, gain_st);
        end
        r.gain = gain_st;
        r.env  = env_st;
        return r;
    endfunction

    // Write one register; the block must be idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_AGC_OFF:   cfg_off      = data[0];
            CFG_ATTACK:    cfg_attack   = data[COEF_W-1:0];
            CFG_DECAY:     cfg_decay    = data[COEF_W-1:0];
            CFG_HANG:      cfg_hang     = data[HANG_W-1:0];
            CFG_THRESHOLD: cfg_thresh   = data[LEVEL_W-1:0];
            CFG_MAX_GAIN:  cfg_max_gain = data[GAIN_W-1:0];
            CFG_TARGET:    cfg_target   = data[LEVEL_W-1:0];
            CFG_MANUAL:    cfg_manual   = data[MANUAL_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample, idling at random first; record its result once the transfer happens.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic first);
        while (!steady_flow && $urandom_range(99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.sample_in      <= s;
        in_ch.first_of_block <= first;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        results_due.push_back(agc_next_output(s, first));
        samples_sent++;
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic report_field(input string field, input logic signed [63:0] want,
                                input logic signed [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Pick a register value: zero, the field maximum, a value in range, or raw 36 bits.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_DATA_W-1:0] top);
        case ($urandom_range(3))
            0:       return '0;
            1:       return top;
            2:       return CFG_DATA_W'({$urandom(), $urandom()} % (64'(top) + 64'd1));
            default: return CFG_DATA_W'({$urandom(), $urandom()});
        endcase
    endfunction

    // Alternate loud bursts and quiet stretches so attack, hang and decay all get exercised.
    function automatic logic signed [SAMPLE_W-1:0] next_test_sample();
        int m;
        if (burst_left == 0) begin
            burst_loud = !burst_loud;
            burst_left = burst_loud ? $urandom_range(6, 1) : $urandom_range(30, 1);
        end
        burst_left--;
        if ($urandom_range(9) < 2)
            return SAMPLE_W'($urandom());
        m = burst_loud ? $urandom_range(32767, 8192) : $urandom_range(300, 0);
        return $urandom_range(1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    // Both envelope and threshold at zero: the target must fall back to max_gain.
    task automatic test_zero_divisor();
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_MAX_GAIN, 36'd200000);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd3, 1'b1);   // attack step rounds to zero, envelope stays at zero
        wait_for_results();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(THRESH_RST));
    endtask

    // Target well above the ceiling must be clamped.
    task automatic test_target_clamp();
        write_reg(CFG_MAX_GAIN, 36'd65536);
        write_reg(CFG_TARGET, CFG_DATA_W'({LEVEL_W{1'b1}}));
        send_sample(16'sd32767, 1'b0);
        send_sample(SAMPLE_W'(-SAMPLE_MIN_MAG), 1'b1);
        wait_for_results();
    endtask

    // Drop the ceiling to zero: the gain must glide down, not be cut.
    task automatic test_gain_glide();
        write_reg(CFG_MAX_GAIN, '0);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sd0, 1'b0);
        wait_for_results();
        write_reg(CFG_MAX_GAIN, CFG_DATA_W'({GAIN_W{1'b1}}));
    endtask

    // Attack, hold through hang, decay; then the coefficient and level extremes.
    task automatic test_hang_and_decay();
        write_reg(CFG_ATTACK, CFG_DATA_W'({COEF_W{1'b1}}));
        write_reg(CFG_DECAY, CFG_DATA_W'({COEF_W{1'b1}}));
        write_reg(CFG_HANG, 36'd2);
        send_sample(16'sd20000, 1'b0);
        repeat (4) send_sample(16'sd100, 1'b0);
        wait_for_results();
        write_reg(CFG_HANG, '0);
        send_sample(-16'sd30000, 1'b0);
        send_sample(16'sd50, 1'b0);
        wait_for_results();
        // Zero coefficients freeze the envelope; longest hang re-arms on every loud sample.
        write_reg(CFG_ATTACK, '0);
        write_reg(CFG_DECAY, '0);
        write_reg(CFG_HANG, CFG_DATA_W'({HANG_W{1'b1}}));
        send_sample(SAMPLE_W'(-SAMPLE_MIN_MAG), 1'b0);
        send_sample(16'sd0, 1'b0);
        wait_for_results();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'({LEVEL_W{1'b1}}));
        send_sample(16'sd12345, 1'b0);
        wait_for_results();
        write_reg(CFG_TARGET, '0);
        send_sample(-16'sd7, 1'b0);
        wait_for_results();
    endtask

    // Manual gain at a large value and at zero, saturation both ways, block restarts of the peak.
    task automatic test_manual_mode();
        write_reg(CFG_AGC_OFF, 36'd1);
        write_reg(CFG_MANUAL, 36'd65536000);
        send_sample(16'sd1000, 1'b1);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'sd5, 1'b0);
        wait_for_results();
        write_reg(CFG_MANUAL, '0);
        send_sample(16'sd32767, 1'b1);
        wait_for_results();
        write_reg(CFG_MANUAL, CFG_DATA_W'(MANUAL_RST));
        send_sample(SAMPLE_W'(-SAMPLE_MIN_MAG), 1'b0);
        wait_for_results();
        write_reg(CFG_AGC_OFF, '0);
    endtask

    // Randomized phases: new settings for every register, then a run of bursty audio.
    task automatic test_random_phases();
        for (int ph = 0; ph < 7; ph++) begin
            wait_for_results();
            write_reg(CFG_AGC_OFF, (ph == 2 || ph == 5) ? 36'd1 : 36'd0);
            write_reg(CFG_ATTACK, pick_setting(CFG_DATA_W'({COEF_W{1'b1}})));
            write_reg(CFG_DECAY, pick_setting(CFG_DATA_W'({COEF_W{1'b1}})));
            // Keep hang mostly short so decay shows up within a phase.
            write_reg(CFG_HANG, ($urandom_range(3) == 0) ?
                                pick_setting(CFG_DATA_W'({HANG_W{1'b1}})) :
                                CFG_DATA_W'($urandom_range(40)));
            write_reg(CFG_THRESHOLD, pick_setting(CFG_DATA_W'({LEVEL_W{1'b1}})));
            write_reg(CFG_MAX_GAIN, pick_setting(CFG_DATA_W'({GAIN_W{1'b1}})));
            write_reg(CFG_TARGET, pick_setting(CFG_DATA_W'({LEVEL_W{1'b1}})));
            write_reg(CFG_MANUAL, pick_setting(CFG_DATA_W'({MANUAL_W{1'b1}})));
            steady_flow = (ph == 3);
            for (int n = 0; n < 105; n++)
                send_sample(next_test_sample(), $urandom_range(7) == 0);
            steady_flow = 1'b0;
            phases_run++;
        end
    endtask

    // Result side: stall at random, compare every transfer with the oldest pending result.
    initial begin
        t_agc_result due;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing pending, sample %0d gain %0d env %0d",
                             $time, out_ch.sample_out, out_ch.gain_now, out_ch.envelope_now);
                end else begin
                    due = results_due.pop_front();
                    report_field("sample_out", due.sample, out_ch.sample_out);
                    report_field("gain_now", due.gain, out_ch.gain_now);
                    report_field("envelope_now", due.env, out_ch.envelope_now);
                end
            end
            out_ch.ready <= steady_flow || ($urandom_range(99) >= 8);
        end
    end

    // Main sequence.
    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_AGC_OFF;
        i_cfg_data           <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.sample_in      <= '0;
        in_ch.first_of_block <= 1'b0;
        cfg_off      = 1'b0;
        cfg_attack   = ATTACK_RST;
        cfg_decay    = DECAY_RST;
        cfg_hang     = HANG_RST;
        cfg_thresh   = THRESH_RST;
        cfg_max_gain = MAX_GAIN_RST;
        cfg_target   = TARGET_RST;
        cfg_manual   = MANUAL_RST;
        env_st       = '0;
        gain_st      = GAIN_RST;
        hang_st      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_divisor();
        test_target_clamp();
        test_gain_glide();
        test_hang_and_decay();
        test_manual_mode();
        test_random_phases();

        // Drain, then give the block a full sample time to show any stray result.
        wait_for_results();
        repeat (64) @(posedge i_clk);
        if (results_due.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d results never arrived", $time, results_due.size());
        end
        $display("Covered %0d samples across directed cases and %0d random register phases,",
                 samples_sent, phases_run);
        $display("automatic and manual modes, %0d results compared, %0d mismatches.",
                 results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: stops the run well beyond its slowest legal length.
    initial begin
        #5_000_000;
        $display("Timeout: %0d results still pending", results_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
src/aahtu_pkg.sv
src/aahtu_in_if.sv
src/aahtu_out_if.sv
src/aahtu_mac.sv
src/aahtu_div.sv
src/audio_agc_hang_threshold_unit.sv
tb/audio_agc_hang_threshold_unit_tb.sv
